### hdl/pcl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcl_pkg
// shared types and constants for the positional circular list
// ----------------------------------------------------------------------------
package pcl_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    localparam int LEN_W  = $clog2(CAPACITY + 1);   // holds 0..CAPACITY
    localparam int ADDR_W = $clog2(CAPACITY);       // one slot of the store
    localparam int OP_W   = 3;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 8;
    localparam int ST_W   = 2;
    localparam int CMP_W  = POS_W + 1;

    // stream words, padded to whole bytes
    localparam int S_TDATA_W = ((OP_W + VAL_W + POS_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ST_W + VAL_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_END   = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_END   = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_READ      = 3'd6,
        OP_NOP       = 3'd7
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MOVE,
        S_PUT,
        S_RESP,
        S_RD_ISSUE,
        S_RD_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic setup;
        logic step;
        logic put;
        logic drop;
        logic emit_status;
        logic emit_entry;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_ins;
        logic is_del;
        logic is_read;
        logic err;
        logic left_zero;
        logic wr_pend;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

### hdl/pcl_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcl_ctrl
// sequencer for one list operation at a time
// ----------------------------------------------------------------------------
module pcl_ctrl import pcl_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.err)
                begin
                    state_next = S_RESP;
                end
                else if (sts.is_ins || sts.is_del)
                begin
                    state_next = S_MOVE;
                end
                else if (sts.is_read)
                begin
                    state_next = S_RD_ISSUE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_MOVE:
            begin
                if (sts.left_zero && !sts.wr_pend)
                begin
                    state_next = sts.is_ins ? S_PUT : S_RESP;
                end
            end
            S_PUT:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RD_ISSUE:
            begin
                state_next = S_RD_EMIT;
            end
            S_RD_EMIT:
            begin
                if (sts.out_free && sts.left_zero)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready = 1'b0;
        cmd      = '0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            S_DECODE:
            begin
                cmd.setup = 1'b1;
            end
            S_MOVE:
            begin
                cmd.step = !sts.left_zero;
                cmd.drop = sts.left_zero && !sts.wr_pend && sts.is_del;
            end
            S_PUT:
            begin
                cmd.put = 1'b1;
            end
            S_RESP:
            begin
                cmd.emit_status = sts.out_free;
            end
            S_RD_ISSUE:
            begin
                cmd.step = 1'b1;
            end
            S_RD_EMIT:
            begin
                cmd.emit_entry = sts.out_free;
                cmd.step       = sts.out_free && !sts.left_zero;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/pcl_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcl_dpath
// entry store, length, walk counters and output register
// ----------------------------------------------------------------------------
module pcl_dpath import pcl_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tlast,
    input  wire cmd_t                 cmd,
    output sts_t                      sts
);

    logic [DATA_WIDTH-1:0] mem [CAPACITY];

    op_t                   op_reg;
    logic [VAL_W-1:0]      value_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [LEN_W-1:0]      len_next;
    logic [LEN_W-1:0]      tgt_reg;
    logic [LEN_W-1:0]      ptr_reg;
    logic [LEN_W-1:0]      left_reg;
    status_t               code_reg;
    logic                  wr_pend_reg;
    logic                  wr_pend_next;
    logic [ADDR_W-1:0]     wr_addr_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    status_t               out_status_reg;
    logic [VAL_W-1:0]      out_value_reg;
    logic                  out_last_reg;

    logic                  is_ins;
    logic                  is_del;
    logic                  is_read;
    logic                  bad_ins;
    logic                  bad_del;
    logic [CMP_W-1:0]      len_cmp;
    logic [CMP_W-1:0]      pos_cmp;
    status_t               code;
    logic [LEN_W-1:0]      tgt;
    logic [LEN_W-1:0]      ptr_init;
    logic [LEN_W-1:0]      left_init;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_wa;
    logic [DATA_WIDTH-1:0] mem_wd;
    logic                  out_free;

    // decode of the captured operation
    always_comb
    begin
        is_ins  = (op_reg == OP_INS_FRONT) || (op_reg == OP_INS_END) ||
                  (op_reg == OP_INS_AT);
        is_del  = (op_reg == OP_DEL_FRONT) || (op_reg == OP_DEL_END) ||
                  (op_reg == OP_DEL_AT);
        is_read = (op_reg == OP_READ);
        len_cmp = CMP_W'(len_reg);
        pos_cmp = CMP_W'(pos_reg);
        bad_ins = (pos_reg == '0) || (pos_cmp > len_cmp + CMP_W'(1));
        bad_del = (pos_reg == '0) || (pos_cmp > len_cmp);

        code = ST_OK;
        if (is_ins)
        begin
            if (len_reg == LEN_W'(CAPACITY))
            begin
                code = ST_FULL;
            end
            else if ((op_reg == OP_INS_AT) && bad_ins)
            begin
                code = ST_BADPOS;
            end
        end
        else if (is_del || is_read)
        begin
            if (len_reg == '0)
            begin
                code = ST_EMPTY;
            end
            else if ((op_reg == OP_DEL_AT) && bad_del)
            begin
                code = ST_BADPOS;
            end
        end

        case (op_reg)
            OP_INS_END: tgt = len_reg;
            OP_INS_AT:  tgt = LEN_W'(pos_reg - POS_W'(1));
            OP_DEL_END: tgt = len_reg - LEN_W'(1);
            OP_DEL_AT:  tgt = LEN_W'(pos_reg - POS_W'(1));
            default:    tgt = '0;
        endcase

        // insert walks down from the tail, delete walks up past the target
        if (is_ins)
        begin
            ptr_init  = len_reg - LEN_W'(1);
            left_init = len_reg - tgt;
        end
        else if (is_del)
        begin
            ptr_init  = tgt + LEN_W'(1);
            left_init = len_reg - LEN_W'(1) - tgt;
        end
        else
        begin
            ptr_init  = '0;
            left_init = len_reg;
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    assign sts.is_ins    = is_ins;
    assign sts.is_del    = is_del;
    assign sts.is_read   = is_read;
    assign sts.err       = (code != ST_OK);
    assign sts.left_zero = (left_reg == '0);
    assign sts.wr_pend   = wr_pend_reg;
    assign sts.out_free  = out_free;

    // single write port: pending shift write or the new entry
    assign mem_we = wr_pend_reg || cmd.put;
    assign mem_wa = wr_pend_reg ? wr_addr_reg : tgt_reg[ADDR_W-1:0];
    assign mem_wd = wr_pend_reg ? rd_data_reg : DATA_WIDTH'(value_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            rd_data_reg <= mem[ptr_reg[ADDR_W-1:0]];
        end
    end

    always_comb
    begin
        len_next = len_reg;
        if (cmd.put)
        begin
            len_next = len_reg + LEN_W'(1);
        end
        else if (cmd.drop)
        begin
            len_next = len_reg - LEN_W'(1);
        end

        wr_pend_next = cmd.step && !is_read;

        out_valid_next = out_valid_reg;
        if (cmd.emit_status || cmd.emit_entry)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            wr_pend_reg   <= wr_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op_t'(s_tdata[OP_W-1:0]);
            value_reg <= s_tdata[OP_W +: VAL_W];
            pos_reg   <= s_tdata[OP_W+VAL_W +: POS_W];
        end
        if (cmd.setup)
        begin
            tgt_reg  <= tgt;
            ptr_reg  <= ptr_init;
            left_reg <= left_init;
            code_reg <= code;
        end
        else if (cmd.step)
        begin
            ptr_reg     <= is_ins ? ptr_reg - LEN_W'(1) : ptr_reg + LEN_W'(1);
            left_reg    <= left_reg - LEN_W'(1);
            wr_addr_reg <= is_ins ? ADDR_W'(ptr_reg + LEN_W'(1))
                                  : ADDR_W'(ptr_reg - LEN_W'(1));
        end
        if (cmd.emit_status)
        begin
            out_status_reg <= code_reg;
            out_value_reg  <= '0;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.emit_entry)
        begin
            out_status_reg <= ST_OK;
            out_value_reg  <= VAL_W'(rd_data_reg);
            out_last_reg   <= (left_reg == '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = M_TDATA_W'({out_value_reg, out_status_reg});

`ifndef NO_ASSERTIONS
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(CAPACITY))
        else $error("list length above capacity");

    a_put_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.put |-> (len_reg < LEN_W'(CAPACITY)))
        else $error("insert into a full list");

    a_drop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drop |-> (len_reg != '0))
        else $error("delete from an empty list");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_status || cmd.emit_entry) |-> out_free)
        else $error("output register overwritten before it was taken");

    a_port_conflict: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_pend_reg && cmd.put))
        else $error("shift write and new entry write in the same cycle");
`endif

endmodule

`default_nettype wire

### hdl/positional_circular_list_top.sv
`default_nettype none
// insert and delete answer after m entries (up to CAPACITY-1) are shifted one per cycle
// full, empty or bad position answers come without any shift; read out gives one word
//   per cycle while m_tready is high
// one item at a time: a new word is accepted only in idle, and output stalls hold the sequencer
// reset: rst_n asynchronous active low, clears length, state and output valid, not the store
// ----------------------------------------------------------------------------
// positional_circular_list_top
// bounded ordered list with positional insert, delete and read out
// ----------------------------------------------------------------------------
module positional_circular_list_top import pcl_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // op[2:0], value[34:3], position[42:35]
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // status[1:0], entry_value[33:2]
    output logic                      m_tlast    // last word of this operation
);

    cmd_t cmd;
    sts_t sts;

    // sequencer: accepts a word in idle, then walks the store through the datapath
    pcl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // store, length, shift pointers and the output register that decouples m_tready
    pcl_dpath u_dpath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

`default_nettype wire
